@@ design/scroll_motion_sample_verifier_top_defines.svh @@
// Assertion shorthands used by the checker file.
`ifndef SCROLL_MOTION_SAMPLE_VERIFIER_TOP_DEFINES_SVH
`define SCROLL_MOTION_SAMPLE_VERIFIER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is held
`define SMSV_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is held
`define SMSV_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/smsv_pkg.sv @@
package smsv_pkg;

	// Pixel and counter widths
	localparam int unsigned PIX_W = 24;
	localparam int unsigned CNT_W = 11;
	localparam int unsigned PCT_W = 7;
	localparam int unsigned CFG_W = 11;
	localparam int unsigned CFG_IDX_W = 2;

	// Counter ceiling: the smaller of the sample budget and the hard cap
	localparam int unsigned MAX_SAMPLES = 1024;
	localparam int unsigned ABS_SAMPLE_CAP = 1024;

	// Register reset values
	localparam logic [CNT_W-1:0] MIN_COMPARED_RST = CNT_W'(16);
	localparam logic [CNT_W-1:0] MIN_INFORMATIVE_RST = CNT_W'(8);
	localparam logic [PCT_W-1:0] OVERALL_PCT_RST = PCT_W'(90);
	localparam logic [PCT_W-1:0] TEXTURED_PCT_RST = PCT_W'(90);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_COMPARED = 2'd0,
		CFG_MIN_INFORMATIVE = 2'd1,
		CFG_OVERALL_PERCENT = 2'd2,
		CFG_TEXTURED_PERCENT = 2'd3
	} smsv_cfg_idx_t;

	// Verdict codes, in test priority order
	typedef enum logic [2:0] {
		VERDICT_ACCEPT = 3'd0,
		VERDICT_FEW_SAMPLES = 3'd1,
		VERDICT_LOW_TEXTURE = 3'd2,
		VERDICT_OVERALL_MISMATCH = 3'd3,
		VERDICT_TEXTURED_MISMATCH = 3'd4
	} smsv_verdict_t;

	// One sample request
	typedef struct packed {
		logic             sample_present;
		logic [PIX_W-1:0] old_center;
		logic [PIX_W-1:0] old_right;
		logic [PIX_W-1:0] old_down;
		logic [PIX_W-1:0] new_center;
		logic [PIX_W-1:0] new_right;
		logic [PIX_W-1:0] new_down;
		logic             last_sample;
	} smsv_in_t;

	// One pass result
	typedef struct packed {
		logic [CNT_W-1:0] compared_count;
		logic [CNT_W-1:0] matched_count;
		logic [CNT_W-1:0] textured_count;
		logic [CNT_W-1:0] textured_matched;
		logic [2:0]       verdict;
	} smsv_out_t;

	// Running pass totals
	typedef struct packed {
		logic [CNT_W-1:0] compared;
		logic [CNT_W-1:0] matched;
		logic [CNT_W-1:0] textured;
		logic [CNT_W-1:0] textured_matched;
	} smsv_counts_t;

endpackage

@@ design/scroll_motion_sample_verifier_top.sv @@
// Channel  | Signals                              | Moves
// ---------+--------------------------------------+------------------------------
// sample   | sample_valid, sample_stall, sample   | one sample pair or closer in
// result   | result_valid, result_stall, result   | counts and verdict per pass
// cfg      | cfg_we, cfg_index, cfg_data          | register writes, no read-back
//
// One sample request is taken per cycle while sample_stall is low. A closing request
// passes the input register, then the count stage, then the verdict/output register.
// Reset clears the counters, the valid bits and the registers to their defaults.
// Only result_stall holds back the sample side: intake stops when a closing request
// waits in the input register behind a full count stage and a stalled output.
module scroll_motion_sample_verifier_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  smsv_pkg::smsv_in_t                  sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output smsv_pkg::smsv_out_t                 result,
	input  logic                                cfg_we,
	input  logic [smsv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [smsv_pkg::CFG_W-1:0]          cfg_data
);
	import smsv_pkg::*;

	localparam int unsigned CNT_LIMIT_I =
		(MAX_SAMPLES < ABS_SAMPLE_CAP) ? MAX_SAMPLES : ABS_SAMPLE_CAP;
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CNT_LIMIT_I);
	localparam int unsigned PROD_W = CNT_W + PCT_W;
	localparam logic [PROD_W-1:0] PCT_FULL = PROD_W'(100);

	// Saturating increment
	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (c < CNT_LIMIT) ? c + CNT_W'(1) : c;
	endfunction

	// num/den >= pct/100, never met with an empty denominator
	function automatic logic pct_ok(input logic [CNT_W-1:0] num,
			input logic [CNT_W-1:0] den, input logic [PCT_W-1:0] pct);
		logic [PROD_W-1:0] lhs;
		logic [PROD_W-1:0] rhs;
		lhs = PROD_W'(num) * PCT_FULL;
		rhs = PROD_W'(den) * PROD_W'(pct);
		return (den != '0) && (lhs >= rhs);
	endfunction

	logic [CNT_W-1:0] min_compared_q;
	logic [CNT_W-1:0] min_informative_q;
	logic [PCT_W-1:0] overall_pct_q;
	logic [PCT_W-1:0] textured_pct_q;

	logic         valid_s1;
	smsv_in_t     sample_s1;
	smsv_counts_t cnt_q;
	smsv_counts_t cnt_next;
	logic         res_valid_s2;
	smsv_counts_t res_s2;
	logic         result_valid_q;
	smsv_out_t    result_q;

	logic          s1_go;
	logic          s2_go;
	logic          take;
	logic          match;
	logic          textured;
	smsv_verdict_t verdict;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_compared_q <= MIN_COMPARED_RST;
			min_informative_q <= MIN_INFORMATIVE_RST;
			overall_pct_q <= OVERALL_PCT_RST;
			textured_pct_q <= TEXTURED_PCT_RST;
		end else if (cfg_we) begin
			unique case (smsv_cfg_idx_t'(cfg_index))
				CFG_MIN_COMPARED:     min_compared_q <= cfg_data;
				CFG_MIN_INFORMATIVE:  min_informative_q <= cfg_data;
				CFG_OVERALL_PERCENT:  overall_pct_q <= cfg_data[PCT_W-1:0];
				CFG_TEXTURED_PERCENT: textured_pct_q <= cfg_data[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// Flow control: stall propagates back from the output register
	assign s2_go = res_valid_s2 && (!result_valid_q || !result_stall);
	assign s1_go = valid_s1 && !(sample_s1.last_sample && res_valid_s2 && !s2_go);
	assign sample_stall = valid_s1 && !s1_go;
	assign take = sample_valid && !sample_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1 <= sample;
		end
	end

	// Per-sample classification and counter update
	assign match = (sample_s1.old_center == sample_s1.new_center) &&
		(sample_s1.old_right == sample_s1.new_right) &&
		(sample_s1.old_down == sample_s1.new_down);
	assign textured = (sample_s1.old_center != sample_s1.old_right) ||
		(sample_s1.old_center != sample_s1.old_down);

	always_comb begin
		cnt_next = cnt_q;
		if (sample_s1.sample_present) begin
			cnt_next.compared = bump(cnt_q.compared);
			if (match) begin
				cnt_next.matched = bump(cnt_q.matched);
			end
			if (textured) begin
				cnt_next.textured = bump(cnt_q.textured);
				if (match) begin
					cnt_next.textured_matched = bump(cnt_q.textured_matched);
				end
			end
		end
	end

	// Counters clear after a closing request hands its totals on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (s1_go) begin
			cnt_q <= sample_s1.last_sample ? '0 : cnt_next;
		end
	end

	// Count stage: finished totals of one pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (s1_go && sample_s1.last_sample) begin
			res_valid_s2 <= 1'b1;
		end else if (s2_go) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && sample_s1.last_sample) begin
			res_s2 <= cnt_next;
		end
	end

	// Verdict, tests in priority order
	always_comb begin
		if (res_s2.compared < min_compared_q) begin
			verdict = VERDICT_FEW_SAMPLES;
		end else if (res_s2.textured < min_informative_q) begin
			verdict = VERDICT_LOW_TEXTURE;
		end else if (!pct_ok(res_s2.matched, res_s2.compared, overall_pct_q)) begin
			verdict = VERDICT_OVERALL_MISMATCH;
		end else if (!pct_ok(res_s2.textured_matched, res_s2.textured,
				textured_pct_q)) begin
			verdict = VERDICT_TEXTURED_MISMATCH;
		end else begin
			verdict = VERDICT_ACCEPT;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s2_go) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			result_q.compared_count <= res_s2.compared;
			result_q.matched_count <= res_s2.matched;
			result_q.textured_count <= res_s2.textured;
			result_q.textured_matched <= res_s2.textured_matched;
			result_q.verdict <= verdict;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

@@ design/smsv_checker.sv @@
`include "scroll_motion_sample_verifier_top_defines.svh"

module smsv_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                sample_valid,
	input logic                sample_stall,
	input logic                result_valid,
	input logic                result_stall,
	input smsv_pkg::smsv_out_t result
);
	import smsv_pkg::*;

	// A stalled result stays put
	`SMSV_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "result changed while stalled")

	// Intake only stops behind a waiting result
	`SMSV_ASSERT_IMP(a_stall_cause, !result_valid, !sample_stall, "sample stalled with output empty")

	// Matches never outnumber compares
	`SMSV_ASSERT_IMP(a_match_bound, result_valid, result.matched_count <= result.compared_count, "matched above compared")

	// Textured subset ordering
	`SMSV_ASSERT_IMP(a_tex_bound, result_valid, (result.textured_matched <= result.textured_count) && (result.textured_count <= result.compared_count), "textured counts out of order")

	// Acceptance needs textured samples to judge
	`SMSV_ASSERT_IMP(a_accept_nonempty, result_valid && (result.verdict == VERDICT_ACCEPT), result.textured_count != '0, "accept with no textured sample")

endmodule

bind scroll_motion_sample_verifier_top smsv_checker u_smsv_checker (.*);

@@ tb/sv/tb_scroll_motion_sample_verifier_top.sv @@
`timescale 1ns / 100ps

module tb_scroll_motion_sample_verifier_top;
	import smsv_pkg::*;

	// Counter ceiling: the smaller of the sample budget and the hard cap
	localparam int unsigned COUNT_LIMIT =
		(MAX_SAMPLES < ABS_SAMPLE_CAP) ? MAX_SAMPLES : ABS_SAMPLE_CAP;
	localparam int unsigned RANDOM_ITEMS = 900;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned PRINT_CAP = 40;
	localparam logic [PIX_W-1:0] ALL1 = '1;

	// Tracks pass totals and the verdicts still to come out of the block
	class scroll_verdict_tracker;
		logic [CNT_W-1:0] min_compared_r;
		logic [CNT_W-1:0] min_informative_r;
		logic [PCT_W-1:0] overall_pct_r;
		logic [PCT_W-1:0] textured_pct_r;
		smsv_counts_t     run;
		smsv_out_t        awaited_results[$];
		int unsigned      mismatches;
		int unsigned      results_seen;
		int unsigned      verdict_hits[5];

		function new();
			min_compared_r = MIN_COMPARED_RST;
			min_informative_r = MIN_INFORMATIVE_RST;
			overall_pct_r = OVERALL_PCT_RST;
			textured_pct_r = TEXTURED_PCT_RST;
			run = '0;
			mismatches = 0;
			results_seen = 0;
			foreach (verdict_hits[i]) verdict_hits[i] = 0;
		endfunction

		function void set_register(smsv_cfg_idx_t idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_MIN_COMPARED: min_compared_r = data[CNT_W-1:0];
				CFG_MIN_INFORMATIVE: min_informative_r = data[CNT_W-1:0];
				CFG_OVERALL_PERCENT: overall_pct_r = data[PCT_W-1:0];
				CFG_TEXTURED_PERCENT: textured_pct_r = data[PCT_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
			return (32'(c) < COUNT_LIMIT) ? c + 1'b1 : c;
		endfunction

		// Empty denominator never passes
		function bit percent_met(logic [CNT_W-1:0] num, logic [CNT_W-1:0] den,
			logic [PCT_W-1:0] pct);
			return (den != 0) && ((32'(num) * 100) >= (32'(den) * 32'(pct)));
		endfunction

		function void note_request(smsv_in_t req);
			bit            same;
			bit            textured;
			smsv_out_t     want;
			smsv_verdict_t v;
			if (req.sample_present) begin
				same = (req.old_center == req.new_center) &&
					(req.old_right == req.new_right) && (req.old_down == req.new_down);
				textured = (req.old_center != req.old_right) ||
					(req.old_center != req.old_down);
				run.compared = bump(run.compared);
				if (same) run.matched = bump(run.matched);
				if (textured) begin
					run.textured = bump(run.textured);
					if (same) run.textured_matched = bump(run.textured_matched);
				end
			end
			if (!req.last_sample) return;
			// Verdict tests in priority order
			if (run.compared < min_compared_r)
				v = VERDICT_FEW_SAMPLES;
			else if (run.textured < min_informative_r)
				v = VERDICT_LOW_TEXTURE;
			else if (!percent_met(run.matched, run.compared, overall_pct_r))
				v = VERDICT_OVERALL_MISMATCH;
			else if (!percent_met(run.textured_matched, run.textured, textured_pct_r))
				v = VERDICT_TEXTURED_MISMATCH;
			else
				v = VERDICT_ACCEPT;
			want.compared_count = run.compared;
			want.matched_count = run.matched;
			want.textured_count = run.textured;
			want.textured_matched = run.textured_matched;
			want.verdict = v;
			awaited_results.push_back(want);
			run = '0;
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_result(smsv_out_t got);
			smsv_out_t want;
			results_seen++;
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("result with no pass pending (verdict %0d)",
					got.verdict));
				return;
			end
			want = awaited_results.pop_front();
			verdict_hits[want.verdict]++;
			if (got.compared_count !== want.compared_count)
				report_mismatch($sformatf("compared_count exp %0d got %0d",
					want.compared_count, got.compared_count));
			if (got.matched_count !== want.matched_count)
				report_mismatch($sformatf("matched_count exp %0d got %0d",
					want.matched_count, got.matched_count));
			if (got.textured_count !== want.textured_count)
				report_mismatch($sformatf("textured_count exp %0d got %0d",
					want.textured_count, got.textured_count));
			if (got.textured_matched !== want.textured_matched)
				report_mismatch($sformatf("textured_matched exp %0d got %0d",
					want.textured_matched, got.textured_matched));
			if (got.verdict !== want.verdict)
				report_mismatch($sformatf("verdict exp %0d got %0d",
					want.verdict, got.verdict));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_stall;
	smsv_in_t             sample = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	smsv_out_t            result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	scroll_verdict_tracker board;
	int unsigned src_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned items_sent = 0;
	int unsigned passes_sent = 0;

	scroll_motion_sample_verifier_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("** scroll_motion_sample_verifier_top: FAILED **");
		$finish;
	end

	// Accepted requests feed the predictor
	always @(posedge clk) begin
		if (arst_n && sample_valid && !sample_stall) board.note_request(sample);
	end

	// Result side: check accepted results, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) board.check_result(result);
		result_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom());
		endcase
	endfunction

	function automatic smsv_in_t pixel_item(logic present, logic last,
		logic [PIX_W-1:0] oc, logic [PIX_W-1:0] orr, logic [PIX_W-1:0] od,
		logic [PIX_W-1:0] nc, logic [PIX_W-1:0] nr, logic [PIX_W-1:0] nd);
		smsv_in_t req;
		req.sample_present = present;
		req.old_center = oc;
		req.old_right = orr;
		req.old_down = od;
		req.new_center = nc;
		req.new_right = nr;
		req.new_down = nd;
		req.last_sample = last;
		return req;
	endfunction

	// Empty request with garbage pixels
	function automatic smsv_in_t noise_item();
		return pixel_item(1'b0, 1'b0, rand_pixel(), rand_pixel(), rand_pixel(),
			rand_pixel(), rand_pixel(), rand_pixel());
	endfunction

	// Sample pair with chosen match and texture
	function automatic smsv_in_t make_sample(bit same, bit textured);
		logic [PIX_W-1:0] oc, orr, od, nc, nr, nd, flip;
		oc = rand_pixel();
		orr = oc;
		od = oc;
		if (textured) begin
			case ($urandom_range(2))
				0: orr = rand_pixel();
				1: od = rand_pixel();
				default: begin
					orr = rand_pixel();
					od = rand_pixel();
				end
			endcase
			if (orr == oc && od == oc) orr = ~oc;
		end
		nc = oc;
		nr = orr;
		nd = od;
		if (!same) begin
			if ($urandom_range(1))
				flip = PIX_W'(1) << $urandom_range(PIX_W - 1);
			else
				flip = PIX_W'($urandom_range(1, 24'hFFFFFF));
			case ($urandom_range(2))
				0: nc = nc ^ flip;
				1: nr = nr ^ flip;
				default: nd = nd ^ flip;
			endcase
		end
		return pixel_item(1'b1, 1'b0, oc, orr, od, nc, nr, nd);
	endfunction

	function automatic logic [CFG_W-1:0] pick_minimum();
		case ($urandom_range(11))
			0: return '0;
			1: return CFG_W'(1);
			2: return CFG_W'(1024);
			3: return '1;
			default: return CFG_W'($urandom_range(1, 24));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_percent();
		case ($urandom_range(11))
			0: return '0;
			1: return CFG_W'(1);
			2: return CFG_W'(100);
			3: return CFG_W'(127);
			4: return CFG_W'($urandom());
			default: return CFG_W'($urandom_range(50, 100));
		endcase
	endfunction

	task automatic set_idling(int unsigned phase);
		case (phase % 4)
			0: begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
			end
			1: begin
				src_idle_pct = 72;
				sink_stall_pct = 0;
			end
			2: begin
				src_idle_pct = 0;
				sink_stall_pct = 72;
			end
			default: begin
				src_idle_pct = 21;
				sink_stall_pct = 21;
			end
		endcase
	endtask

	// One request through the valid/stall handshake
	task automatic send_request(smsv_in_t req);
		while ($urandom_range(99) < src_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= req;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		if (req.sample_present || req.last_sample) items_sent++;
		if (req.last_sample) passes_sent++;
	endtask

	// Hold the sender until every pending result is out, then let the pipe settle
	task automatic drain_results();
		sample_valid <= 1'b0;
		@(negedge clk);
		while (board.awaited_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all four registers while the block is idle
	task automatic program_registers(logic [CFG_W-1:0] mc, logic [CFG_W-1:0] mi,
		logic [CFG_W-1:0] op, logic [CFG_W-1:0] tp);
		logic [CFG_W-1:0] vals[4];
		smsv_cfg_idx_t    idx;
		drain_results();
		vals = '{mc, mi, op, tp};
		idx = idx.first();
		repeat (idx.num()) begin
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= vals[idx];
			board.set_register(idx, vals[idx]);
			@(posedge clk);
			idx = idx.next();
		end
		cfg_we <= 1'b0;
	endtask

	// A pass of n samples plus a closer, with sprinkled empty requests
	task automatic run_pass(int unsigned n, int unsigned match_pct, int unsigned tex_pct);
		smsv_in_t req;
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(99) < 10) send_request(noise_item());
			send_request(make_sample($urandom_range(99) < match_pct,
				$urandom_range(99) < tex_pct));
		end
		if ($urandom_range(1))
			req = make_sample($urandom_range(99) < match_pct, $urandom_range(99) < tex_pct);
		else
			req = noise_item();
		req.last_sample = 1'b1;
		send_request(req);
	endtask

	initial begin
		int unsigned start_items;
		int unsigned pass_no;
		int unsigned match_pct;
		int unsigned tex_pct;
		smsv_in_t    req;

		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset registers: an empty closer is too few samples
		send_request(pixel_item(1'b0, 1'b1, '0, '0, '0, '0, '0, '0));

		// Zero minimums: empty pass fails on zero denominator
		program_registers(CFG_W'(0), CFG_W'(0), CFG_W'(100), CFG_W'(100));
		send_request(pixel_item(1'b0, 1'b1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1));
		// Flat samples only: no textured samples, sample on closer counted
		send_request(pixel_item(1'b1, 1'b0, '0, '0, '0, '0, '0, '0));
		send_request(pixel_item(1'b0, 1'b0, ALL1, '0, ALL1, '0, ALL1, '0));
		send_request(pixel_item(1'b1, 1'b1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1));

		// Thresholds all set to one: texture via right, via down, via both
		program_registers(CFG_W'(1), CFG_W'(1), CFG_W'(1), CFG_W'(1));
		send_request(pixel_item(1'b1, 1'b0, '0, ALL1, '0, ALL1, ALL1, '0));
		send_request(pixel_item(1'b1, 1'b0, ALL1, ALL1, '0, ALL1, ALL1, ALL1));
		send_request(pixel_item(1'b1, 1'b1, '0, ALL1, ALL1, '0, ALL1, ALL1));

		// Each rejection in turn, percent above 100 among them
		program_registers('1, CFG_W'(1), CFG_W'(50), CFG_W'(50));
		req = make_sample(1'b1, 1'b1);
		req.last_sample = 1'b1;
		send_request(req);
		program_registers(CFG_W'(1), '1, CFG_W'(50), CFG_W'(50));
		send_request(req);
		program_registers(CFG_W'(1), CFG_W'(1), CFG_W'(127), CFG_W'(50));
		send_request(req);
		program_registers(CFG_W'(1), CFG_W'(1), CFG_W'(100), CFG_W'(127));
		send_request(req);

		// Zero percents: an empty pass still fails overall, zero matches pass overall, textured still has no denominator
		program_registers('0, '0, '0, '0);
		send_request(pixel_item(1'b0, 1'b1, '0, '0, '0, '0, '0, '0));
		send_request(pixel_item(1'b1, 1'b0, '0, '0, '0, ALL1, '0, '0));
		send_request(pixel_item(1'b1, 1'b1, ALL1, ALL1, ALL1, ALL1, ALL1, '0));

		// Random passes under changing registers and idling
		start_items = items_sent;
		pass_no = 0;
		while (items_sent - start_items < RANDOM_ITEMS) begin
			if (pass_no % 6 == 0)
				program_registers(pick_minimum(), pick_minimum(), pick_percent(),
					pick_percent());
			if (pass_no % 3 == 0) set_idling(pass_no / 3);
			case ($urandom_range(4))
				0: match_pct = 100;
				1: match_pct = 97;
				2: match_pct = 90;
				3: match_pct = 70;
				default: match_pct = 30;
			endcase
			case ($urandom_range(3))
				0: tex_pct = 100;
				1: tex_pct = 90;
				2: tex_pct = 50;
				default: tex_pct = 5;
			endcase
			run_pass($urandom_range(0, 30), match_pct, tex_pct);
			pass_no++;
		end

		// One pass long enough to saturate all four counters
		program_registers(CFG_W'(1024), CFG_W'(1024), CFG_W'(90), CFG_W'(90));
		set_idling(3);
		run_pass(COUNT_LIMIT + 6, 100, 100);

		drain_results();
		$display("Covered %0d requests over %0d passes, %0d results checked",
			items_sent, passes_sent, board.results_seen);
		$display("Verdicts: accept %0d, few %0d, low texture %0d, overall %0d, textured %0d",
			board.verdict_hits[VERDICT_ACCEPT], board.verdict_hits[VERDICT_FEW_SAMPLES],
			board.verdict_hits[VERDICT_LOW_TEXTURE],
			board.verdict_hits[VERDICT_OVERALL_MISMATCH],
			board.verdict_hits[VERDICT_TEXTURED_MISMATCH]);
		if (board.mismatches == 0)
			$display("** scroll_motion_sample_verifier_top: PASSED **");
		else
			$display("** scroll_motion_sample_verifier_top: FAILED **");
		$finish;
	end

endmodule

@@ scroll_motion_sample_verifier_top.f @@
+incdir+design
design/smsv_pkg.sv
design/scroll_motion_sample_verifier_top.sv
design/smsv_checker.sv
tb/sv/tb_scroll_motion_sample_verifier_top.sv
